### rtl/owdm_pkg.sv
// Shared types and constants of the omni wheel drive mixer.
`default_nettype none

package owdm_pkg;

  // Fixed formats of the command and drive words
  localparam int WHEEL_COUNT = 4;
  localparam int FIELD_W     = 16;
  localparam int REG_W       = 15;
  localparam int FRAC_BITS   = 14;
  localparam int PROD_W      = 30;  // x * 0.7071 in Q2.28
  localparam int RAW_W       = 32;  // raw drive in Q4.28, signed
  localparam int MAG_W       = 31;  // magnitude of a raw drive or divisor
  localparam int NUM_W       = MAG_W + REG_W;  // magnitude times output scale
  localparam int Q_W         = REG_W;          // quotient never exceeds the scale

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // 0.7071 in Q1.14
  localparam logic signed [PROD_W-1:0] COS45_Q14 = PROD_W'(11585);

  // Per wheel: set bit means the x or y term enters negated
  localparam logic [WHEEL_COUNT-1:0] WHEEL_SX_NEG = 4'b0011;
  localparam logic [WHEEL_COUNT-1:0] WHEEL_SY_NEG = 4'b0110;

  // Register reset values
  localparam logic [REG_W-1:0] OUTPUT_SCALE_RESET = 15'd15565;
  localparam logic [REG_W-1:0] NORM_FLOOR_RESET   = 15'd9830;

  // Register indexes
  localparam int REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_OUTPUT_SCALE = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_NORM_FLOOR   = 1'b1;

  // One classified command: magnitudes, signs and the divisor
  typedef struct packed {
    logic [WHEEL_COUNT-1:0][MAG_W-1:0] mag;
    logic [WHEEL_COUNT-1:0]            neg;
    logic [MAG_W-1:0]                  dvs;
  } job_t;

  // Occupancy of the front pipeline
  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } front_stat_t;

  // Quotients leaving the divider
  typedef struct packed {
    logic                            valid;
    logic [WHEEL_COUNT-1:0]          neg;
    logic [WHEEL_COUNT-1:0][Q_W-1:0] q;
  } res_t;

endpackage

`default_nettype wire

### rtl/owdm_front.sv
// Front part: mixes a command into raw wheel drives and finds the divisor.
`default_nettype none

module owdm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic signed [15:0]            move_x,
  input  wire logic signed [15:0]            move_y,
  input  wire logic signed [15:0]            turn_rate,
  input  wire logic [owdm_pkg::REG_W-1:0]    norm_floor,
  output owdm_pkg::job_t                     job,
  output logic                               job_push,
  output owdm_pkg::front_stat_t              stat
);
  import owdm_pkg::*;

  logic                     a_valid;
  logic                     b_valid;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [FIELD_W-1:0] rt;
  logic signed [RAW_W-1:0]  raw [WHEEL_COUNT];
  logic [MAG_W-1:0]         mag_b [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0]   neg_b;
  logic [MAG_W-1:0]         max01;
  logic [MAG_W-1:0]         max23;
  logic [MAG_W-1:0]         max_all;
  logic [MAG_W-1:0]         floor_q;
  logic [MAG_W-1:0]         dvs;

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  // Stage a: scale the x and y terms by 0.7071
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= PROD_W'(move_x) * COS45_Q14;
      py <= PROD_W'(move_y) * COS45_Q14;
      rt <= turn_rate;
    end
  end

  // Sum the terms of each wheel
  always_comb begin
    logic signed [RAW_W-1:0] xs;
    logic signed [RAW_W-1:0] ys;
    logic signed [RAW_W-1:0] rs;
    xs = RAW_W'(px);
    ys = RAW_W'(py);
    rs = RAW_W'(rt) <<< FRAC_BITS;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      raw[i] = (WHEEL_SX_NEG[i] ? -xs : xs) + (WHEEL_SY_NEG[i] ? -ys : ys) + rs;
    end
  end

  // Stage b: split each raw drive into magnitude and sign
  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        mag_b[i] <= raw[i][RAW_W-1] ? MAG_W'(-raw[i]) : MAG_W'(raw[i]);
        neg_b[i] <= raw[i][RAW_W-1];
      end
    end
  end

  // Take the largest magnitude against the floor; a zero divisor only
  // occurs with all drives zero, so one gives the same zero quotients
  always_comb begin
    floor_q = MAG_W'({norm_floor, FRAC_BITS'(0)});
    max01   = (mag_b[0] > mag_b[1]) ? mag_b[0] : mag_b[1];
    max23   = (mag_b[2] > mag_b[3]) ? mag_b[2] : mag_b[3];
    max_all = (max01 > max23) ? max01 : max23;
    dvs     = (max_all > floor_q) ? max_all : floor_q;
    if (dvs == '0) begin
      dvs = MAG_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      job.mag[i] = mag_b[i];
    end
    job.neg = neg_b;
    job.dvs = dvs;
  end

  assign job_push     = b_valid;
  assign stat.a_valid = a_valid;
  assign stat.b_valid = b_valid;

endmodule

`default_nettype wire

### rtl/owdm_queue.sv
// Short queue of classified commands between the front and back parts.
`default_nettype none

module owdm_queue #(
  parameter int DEPTH = owdm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_valid,
  input  wire owdm_pkg::job_t              wr_job,
  input  wire logic                        rd_en,
  output owdm_pkg::job_t                   rd_job,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);
  import owdm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_rd;

  assign do_rd  = rd_en && (count != '0);
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(wr_valid) - CNT_W'(do_rd);
    end
  end

endmodule

`default_nettype wire

### rtl/owdm_back.sv
// Back part: scales each magnitude and divides it by the divisor, one bit a stage.
`default_nettype none

module owdm_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic                       job_valid,
  input  wire owdm_pkg::job_t             job,
  input  wire logic [owdm_pkg::REG_W-1:0] output_scale,
  output owdm_pkg::res_t                  res
);
  import owdm_pkg::*;

  // Index 0 holds the products, index s+1 the result of quotient step s
  logic [NUM_W-1:0]       rem     [Q_W+1][WHEEL_COUNT];
  logic [Q_W-1:0]         quo     [Q_W+1][WHEEL_COUNT];
  logic [MAG_W-1:0]       dvs     [Q_W+1];
  logic [WHEEL_COUNT-1:0] neg     [Q_W+1];
  logic                   vld     [Q_W+1];
  logic [NUM_W-1:0]       rem_nxt [Q_W][WHEEL_COUNT];
  logic [Q_W-1:0]         quo_nxt [Q_W][WHEEL_COUNT];

  // One restoring step per stage, from the top quotient bit down
  always_comb begin
    logic [NUM_W-1:0] shifted;
    for (int s = 0; s < Q_W; s++) begin
      shifted = NUM_W'(dvs[s]) << (Q_W - 1 - s);
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        if (rem[s][i] >= shifted) begin
          rem_nxt[s][i] = rem[s][i] - shifted;
          quo_nxt[s][i] = quo[s][i] | (Q_W'(1) << (Q_W - 1 - s));
        end else begin
          rem_nxt[s][i] = rem[s][i];
          quo_nxt[s][i] = quo[s][i];
        end
      end
    end
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= Q_W; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= job_valid;
      for (int s = 0; s < Q_W; s++) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  // Load the products, then shift the partial remainders down the line
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        rem[0][i] <= NUM_W'(job.mag[i]) * NUM_W'(output_scale);
        quo[0][i] <= '0;
      end
      dvs[0] <= job.dvs;
      neg[0] <= job.neg;
      for (int s = 0; s < Q_W; s++) begin
        for (int i = 0; i < WHEEL_COUNT; i++) begin
          rem[s+1][i] <= rem_nxt[s][i];
          quo[s+1][i] <= quo_nxt[s][i];
        end
        dvs[s+1] <= dvs[s];
        neg[s+1] <= neg[s];
      end
    end
  end

  always_comb begin
    res.valid = vld[Q_W];
    res.neg   = neg[Q_W];
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      res.q[i] = quo[Q_W][i];
    end
  end

endmodule

`default_nettype wire

### rtl/omni_wheel_drive_mixer.sv
// Top level of the four wheel omni drive mixer.
//
//  channel   handshake      words
//  command   push / full    move_x, move_y, turn_rate
//  drives    empty / pop    wheel_front_left, wheel_rear_left,
//                           wheel_rear_right, wheel_front_right
//  config    wr_en          wr_index, wr_data
//
// One command a cycle while full is low, one set of four drives per command; a command
// accepted passes two front stages, the queue, one multiply stage, a 15 stage divider
// (one quotient bit each) and the output register before it can be popped.
// Reset empties every stage and loads the registers with 0.95 and 0.6.
// With a word waiting and pop low the divider and output hold; full rises once
// the queue and the two front stages together hold QUEUE_DEPTH words.
`default_nettype none

module omni_wheel_drive_mixer #(
  parameter int QUEUE_DEPTH = owdm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic signed [15:0]               move_x,
  input  wire logic signed [15:0]               move_y,
  input  wire logic signed [15:0]               turn_rate,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [15:0]                    wheel_front_left,
  output logic signed [15:0]                    wheel_rear_left,
  output logic signed [15:0]                    wheel_rear_right,
  output logic signed [15:0]                    wheel_front_right,
  input  wire logic                             wr_en,
  input  wire logic [owdm_pkg::REG_INDEX_W-1:0] wr_index,
  input  wire logic [owdm_pkg::REG_W-1:0]       wr_data
);
  import owdm_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [REG_W-1:0]   output_scale;
  logic [REG_W-1:0]   norm_floor;
  logic               accept;
  logic               advance;
  logic               out_valid;
  job_t               front_job;
  logic               front_push;
  front_stat_t        front_stat;
  job_t               head_job;
  logic               queue_empty;
  logic [CNT_W-1:0]   queue_count;
  res_t               res;
  logic [CNT_W:0]     held;
  logic signed [FIELD_W-1:0] drive [WHEEL_COUNT];

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_scale <= OUTPUT_SCALE_RESET;
      norm_floor   <= NORM_FLOOR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_OUTPUT_SCALE: output_scale <= wr_data;
        REG_NORM_FLOOR:   norm_floor   <= wr_data;
        default:          ;
      endcase
    end
  end

  // Count words in the queue and in flight in the front
  assign held = (CNT_W+1)'(queue_count) + (CNT_W+1)'(front_stat.a_valid)
              + (CNT_W+1)'(front_stat.b_valid);
  assign full    = (held >= (CNT_W+1)'(QUEUE_DEPTH));
  assign accept  = push && !full;
  assign empty   = !out_valid;
  assign advance = !out_valid || pop;

  owdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .move_x     (move_x),
    .move_y     (move_y),
    .turn_rate  (turn_rate),
    .norm_floor (norm_floor),
    .job        (front_job),
    .job_push   (front_push),
    .stat       (front_stat)
  );

  owdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_push),
    .wr_job   (front_job),
    .rd_en    (advance),
    .rd_job   (head_job),
    .empty    (queue_empty),
    .count    (queue_count)
  );

  owdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .job_valid    (!queue_empty),
    .job          (head_job),
    .output_scale (output_scale),
    .res          (res)
  );

  // Restore the sign of each quotient
  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      drive[i] = res.neg[i] ? -FIELD_W'(res.q[i]) : FIELD_W'(res.q[i]);
    end
  end

  // Hold the result word until it is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wheel_front_left  <= drive[0];
      wheel_rear_left   <= drive[1];
      wheel_rear_right  <= drive[2];
      wheel_front_right <= drive[3];
    end
  end

endmodule

`default_nettype wire

### rtl/owdm_checker.sv
// Port checker of the omni wheel drive mixer and its bind.
`default_nettype none

module owdm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             full,
  input wire logic                             empty,
  input wire logic                             pop,
  input wire logic signed [15:0]               wheel_front_left,
  input wire logic signed [15:0]               wheel_rear_left,
  input wire logic signed [15:0]               wheel_rear_right,
  input wire logic signed [15:0]               wheel_front_right
);

  // Reset leaves no result word waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  // Reset leaves room for a command
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // A waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(wheel_front_left) && $stable(wheel_rear_left)
      && $stable(wheel_rear_right) && $stable(wheel_front_right))
    else $error("result word changed while waiting");

  // Normalised drives never reach the most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> wheel_front_left != 16'sh8000 && wheel_rear_left != 16'sh8000
      && wheel_rear_right != 16'sh8000 && wheel_front_right != 16'sh8000)
    else $error("drive out of range");

endmodule

bind omni_wheel_drive_mixer owdm_checker u_checker (.*);

`default_nettype wire
